>>> sv/mfr_pkg.sv
// ----------------------------------------------------------------------------
// Meter frame receiver package
// Shared constants, status codes and the word types passed between the
// front parser, the decode pipeline and the queues.
// ----------------------------------------------------------------------------
package mfr_pkg;

   localparam int BYTE_W      = 8;
   localparam int POS_W       = 6;
   localparam int ADDR_W      = 56;
   localparam int BCD_W       = 32;
   localparam int VALUE_W     = 28;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 4;

   localparam logic [BYTE_W-1:0] START_BYTE  = 8'h68;
   localparam logic [BYTE_W-1:0] SECOND_BYTE = 8'h10;

   localparam int FRAME_LEN  = 35;
   localparam int SUM_POS    = 33;
   localparam int ADDR_FIRST = 2;
   localparam int ADDR_LAST  = 8;
   localparam int CUR_FIRST  = 14;
   localparam int CUR_LAST   = 17;
   localparam int MON_FIRST  = 19;
   localparam int MON_LAST   = 22;

   localparam logic REG_METER_ADDRESS = 1'b0;

   localparam int JOB_DEPTH = 2;
   localparam int OUT_DEPTH = 2;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ADDR_BAD = 2'd1,
      STATUS_SUM_BAD  = 2'd2,
      STATUS_HDR_BAD  = 2'd3
   } status_type;

   typedef struct packed {
      status_type             status;
      logic [BCD_W-1:0]       current_bcd;
      logic [BCD_W-1:0]       month_bcd;
   } job_type;

   typedef struct packed {
      status_type             status;
      logic [VALUE_W-1:0]     current_hundredths;
      logic [VALUE_W-1:0]     month_hundredths;
   } rsp_type;

endpackage

>>> sv/mfr_fifo.sv
// ----------------------------------------------------------------------------
// Meter frame receiver queue
// Small first-in first-out buffer with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module mfr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> sv/mfr_front.sv
// ----------------------------------------------------------------------------
// Meter frame receiver front end
// Hunts for the frame start, checks header, address and checksum, collects
// the raw BCD bytes and emits one job word per finished or rejected frame.
// ----------------------------------------------------------------------------
module mfr_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [mfr_pkg::BYTE_W-1:0]    rx_byte,
   input  logic [mfr_pkg::ADDR_W-1:0]    meter_address,
   output logic                          job_push,
   output mfr_pkg::job_type              job
);

   localparam int POS_W = mfr_pkg::POS_W;

   logic [POS_W-1:0]              pos_ff, pos_in;
   logic [mfr_pkg::BYTE_W-1:0]    sum_ff, sum_in;
   logic                          addr_bad_ff, addr_bad_in;
   logic [3:0][7:0]               cur_ff, cur_in;
   logic [3:0][7:0]               mon_ff, mon_in;
   logic [7:0][7:0]               addr_bytes;
   logic [2:0]                    addr_idx;
   logic [1:0]                    cur_idx;
   logic [1:0]                    mon_idx;
   logic [POS_W-1:0]              pos_next;

   assign addr_bytes = {8'h00, meter_address};
   assign addr_idx   = 3'(pos_ff - POS_W'(mfr_pkg::ADDR_FIRST));
   assign cur_idx    = 2'(pos_ff - POS_W'(mfr_pkg::CUR_FIRST));
   assign mon_idx    = 2'(pos_ff - POS_W'(mfr_pkg::MON_FIRST));
   assign pos_next   = pos_ff + 1'b1;

   always_comb begin
      pos_in      = pos_ff;
      sum_in      = sum_ff;
      addr_bad_in = addr_bad_ff;
      cur_in      = cur_ff;
      mon_in      = mon_ff;
      job_push    = 1'b0;
      job.status      = mfr_pkg::STATUS_OK;
      job.current_bcd = '0;
      job.month_bcd   = '0;
      if (accept) begin
         if (pos_ff == '0) begin
            if (rx_byte == mfr_pkg::START_BYTE) begin
               sum_in      = rx_byte;
               addr_bad_in = 1'b0;
               cur_in      = '0;
               mon_in      = '0;
               pos_in      = POS_W'(1);
            end
         end else if (pos_ff == POS_W'(1)) begin
            if (rx_byte != mfr_pkg::SECOND_BYTE) begin
               pos_in     = '0;
               job_push   = 1'b1;
               job.status = mfr_pkg::STATUS_HDR_BAD;
            end else begin
               sum_in = sum_ff + rx_byte;
               pos_in = POS_W'(2);
            end
         end else if (pos_ff >= POS_W'(mfr_pkg::FRAME_LEN - 1)) begin
            pos_in   = '0;
            job_push = 1'b1;
            if (addr_bad_ff) begin
               job.status = mfr_pkg::STATUS_ADDR_BAD;
            end else if (sum_ff != '0) begin
               job.status = mfr_pkg::STATUS_SUM_BAD;
            end else begin
               job.status      = mfr_pkg::STATUS_OK;
               job.current_bcd = cur_ff;
               job.month_bcd   = mon_ff;
            end
         end else if (pos_ff == POS_W'(mfr_pkg::SUM_POS)) begin
            sum_in = sum_ff ^ rx_byte;
            pos_in = pos_next;
         end else begin
            sum_in = sum_ff + rx_byte;
            pos_in = pos_next;
            if (pos_ff <= POS_W'(mfr_pkg::ADDR_LAST)) begin
               if (addr_bytes[addr_idx] != rx_byte) begin
                  addr_bad_in = 1'b1;
               end
            end
            if (pos_ff >= POS_W'(mfr_pkg::CUR_FIRST) &&
                pos_ff <= POS_W'(mfr_pkg::CUR_LAST)) begin
               cur_in[cur_idx] = rx_byte;
            end
            if (pos_ff >= POS_W'(mfr_pkg::MON_FIRST) &&
                pos_ff <= POS_W'(mfr_pkg::MON_LAST)) begin
               mon_in[mon_idx] = rx_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         sum_ff      <= '0;
         addr_bad_ff <= 1'b0;
         cur_ff      <= '0;
         mon_ff      <= '0;
      end else begin
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
         addr_bad_ff <= addr_bad_in;
         cur_ff      <= cur_in;
         mon_ff      <= mon_in;
      end
   end

endmodule

>>> sv/mfr_back.sv
// ----------------------------------------------------------------------------
// Meter frame receiver decode pipeline
// Two stages turn the raw BCD words of a job into binary hundredths:
// first each half of four digits, then the halves combined.
// ----------------------------------------------------------------------------
module mfr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_empty,
   input  mfr_pkg::job_type  job,
   output logic              job_pop,
   input  logic              out_full,
   output logic              out_push,
   output mfr_pkg::rsp_type  out_word
);

   localparam int VALUE_W = mfr_pkg::VALUE_W;

   function automatic logic [14:0] bcd4_weight(input logic [15:0] raw);
      logic [14:0] acc;
      acc = 15'(raw[3:0]) + 15'(raw[7:4]) * 15'd10 + 15'(raw[11:8]) * 15'd100
            + 15'(raw[15:12]) * 15'd1000;
      return acc;
   endfunction

   logic                s1_valid_ff, s1_valid_in;
   mfr_pkg::status_type s1_status_ff;
   logic [14:0]         s1_cur_lo_ff, s1_cur_hi_ff, s1_mon_lo_ff, s1_mon_hi_ff;
   logic                s2_valid_ff, s2_valid_in;
   mfr_pkg::rsp_type    s2_word_ff;
   logic                s1_ready;
   logic                s2_ready;

   assign s2_ready    = !s2_valid_ff || !out_full;
   assign s1_ready    = !s1_valid_ff || s2_ready;
   assign job_pop     = !job_empty && s1_ready;
   assign out_push    = s2_valid_ff && !out_full;
   assign out_word    = s2_word_ff;
   assign s1_valid_in = s1_ready ? !job_empty : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         s1_status_ff <= job.status;
         s1_cur_lo_ff <= bcd4_weight(job.current_bcd[15:0]);
         s1_cur_hi_ff <= bcd4_weight(job.current_bcd[31:16]);
         s1_mon_lo_ff <= bcd4_weight(job.month_bcd[15:0]);
         s1_mon_hi_ff <= bcd4_weight(job.month_bcd[31:16]);
      end
      if (s1_valid_ff && s2_ready) begin
         s2_word_ff.status <= s1_status_ff;
         s2_word_ff.current_hundredths <= VALUE_W'(s1_cur_hi_ff) * VALUE_W'(10000)
                                          + VALUE_W'(s1_cur_lo_ff);
         s2_word_ff.month_hundredths <= VALUE_W'(s1_mon_hi_ff) * VALUE_W'(10000)
                                        + VALUE_W'(s1_mon_lo_ff);
      end
   end

endmodule

>>> sv/meter_frame_receiver_bcd.sv
// ----------------------------------------------------------------------------
// Meter frame receiver with BCD value decode
// Top level: configuration register, front parser, job queue, decode
// pipeline and result queue.
// ----------------------------------------------------------------------------
// Received bytes enter on the request side, one word per cycle while full is
// low; full rises only when the job queue backs up behind a stalled result
// side. Each finished frame or rejected header yields one result word with a
// status and two values in hundredths, zero unless the frame is good.
// A result becomes visible once the job of the byte that ends the frame has
// passed the job queue, the two decode stages and the result queue. The front
// part takes one byte every cycle while full is low; results are at most one
// per two bytes; the decode pipeline takes one job per cycle unless stalled.
// If pop stays low, the result queue and then the decode stages fill, the
// job queue fills behind them, and full rises; no word is lost.
// The meter address register is written and read back at one csr address;
// the user must write it only while idle; the block itself does not enforce it.
// Reset clears the parser to hunting, empties both queues and clears the
// meter address; the block accepts bytes in the first cycle after reset.
// ----------------------------------------------------------------------------
module meter_frame_receiver_bcd #(
   parameter int JOB_DEPTH = mfr_pkg::JOB_DEPTH,
   parameter int OUT_DEPTH = mfr_pkg::OUT_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic [mfr_pkg::BYTE_W-1:0]         req_rx_byte,
   output logic                               empty,
   input  logic                               pop,
   output logic [1:0]                         rsp_status,
   output logic [mfr_pkg::VALUE_W-1:0]        rsp_current_hundredths,
   output logic [mfr_pkg::VALUE_W-1:0]        rsp_month_hundredths,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mfr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mfr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mfr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int ADDR_W = mfr_pkg::ADDR_W;

   logic [ADDR_W-1:0] meter_address_ff;
   logic              csr_write;
   logic              accept;
   logic              job_push;
   mfr_pkg::job_type  job_in_word;
   mfr_pkg::job_type  job_out_word;
   logic              job_full;
   logic              job_empty;
   logic              job_pop;
   logic              out_push;
   logic              out_full;
   mfr_pkg::rsp_type  out_in_word;
   mfr_pkg::rsp_type  out_word;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[3] == mfr_pkg::REG_METER_ADDRESS) ?
                       mfr_pkg::CSR_DATA_W'(meter_address_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         meter_address_ff <= '0;
      end else if (csr_write && csr_paddr[3] == mfr_pkg::REG_METER_ADDRESS) begin
         meter_address_ff <= csr_pwdata[ADDR_W-1:0];
      end
   end

   assign full   = job_full;
   assign accept = push && !job_full;

   mfr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .rx_byte       (req_rx_byte),
      .meter_address (meter_address_ff),
      .job_push      (job_push),
      .job           (job_in_word)
   );

   mfr_fifo #(
      .WIDTH ($bits(mfr_pkg::job_type)),
      .DEPTH (JOB_DEPTH)
   ) u_job_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .wr_data (job_in_word),
      .full    (job_full),
      .pop     (job_pop),
      .rd_data (job_out_word),
      .empty   (job_empty)
   );

   mfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job       (job_out_word),
      .job_pop   (job_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_word  (out_in_word)
   );

   mfr_fifo #(
      .WIDTH ($bits(mfr_pkg::rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_in_word),
      .full    (out_full),
      .pop     (pop),
      .rd_data (out_word),
      .empty   (empty)
   );

   assign rsp_status             = out_word.status;
   assign rsp_current_hundredths = out_word.current_hundredths;
   assign rsp_month_hundredths   = out_word.month_hundredths;

   // A rejected frame never carries decoded values.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status != mfr_pkg::STATUS_OK) |->
      (rsp_current_hundredths == '0 && rsp_month_hundredths == '0))
      else $error("nonzero values on a rejected frame");

   // A register write lands in the meter address.
   assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_paddr[3] == mfr_pkg::REG_METER_ADDRESS) |=>
      (meter_address_ff == $past(csr_pwdata[ADDR_W-1:0])))
      else $error("meter address write lost");

   // Out of reset the result queue is empty and the job queue is not full.
   assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not cleared by reset");

endmodule
